// ===== src/weighted_multi_pattern_matcher_macros.svh =====
// assertion macros for the weighted multi-pattern matcher
// expects clk and arst_n in the scope of use
`ifndef WEIGHTED_MULTI_PATTERN_MATCHER_MACROS_SVH
`define WEIGHTED_MULTI_PATTERN_MATCHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define WMPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define WMPM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wmpm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, request/result types and control structs of the matcher
// no dependencies
package wmpm_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int ALPHABET   = 26;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = NODE_W + 1;
	localparam int C_W        = $clog2(ALPHABET);
	localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
	localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
	localparam int VAL_W      = 20;
	localparam int ACC_W      = 40;
	localparam int TOT_W      = 48;

	// request commands
	localparam logic [2:0] CMD_LETTER  = 3'd0;
	localparam logic [2:0] CMD_END     = 3'd1;
	localparam logic [2:0] CMD_BUILD   = 3'd2;
	localparam logic [2:0] CMD_MATCH   = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;
	localparam logic [2:0] CMD_CLEAR   = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [2:0]       command;
		logic [4:0]       char_code;
		logic [VAL_W-1:0] pattern_value;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [NODE_W-1:0] node;
		logic [ACC_W-1:0]  step_score;
		logic [TOT_W-1:0]  total_score;
	} res_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic err;
		logic ins_rd;
		logic ins_wr;
		logic end_rd;
		logic end_wr;
		logic mat_rd;
		logic mat_acc;
		logic mat_fin;
		logic restart;
		logic clr_all;
		logic sweep;
		logic b_init;
		logic b_pop;
		logic b_popw;
		logic b_link;
		logic b_acc;
		logic b_rd1;
		logic b_rd2;
		logic b_wr;
		logic b_fin;
	} ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic bad;
		logic sweep_last;
		logic c_last;
		logic q_more;
	} stat_t;

	// first goto-table address of a node's row
	function automatic logic [GOTO_AW-1:0] row_base(input logic [NODE_W-1:0] n);
		return GOTO_AW'(n) * GOTO_AW'(ALPHABET);
	endfunction

endpackage

// ===== src/wmpm_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module wmpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, old data on collision
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/wmpm_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine of the matcher: request dispatch, build sequence, clearing sweep
// depends on wmpm_pkg
module wmpm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2:0]      command,
	input  wmpm_pkg::stat_t stat,
	output wmpm_pkg::ctl_t  ctl,
	output logic            busy
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_INS2  = 4'd2;
	localparam logic [3:0] S_END2  = 4'd3;
	localparam logic [3:0] S_MAT2  = 4'd4;
	localparam logic [3:0] S_MAT3  = 4'd5;
	localparam logic [3:0] S_BPOP  = 4'd6;
	localparam logic [3:0] S_BPOPW = 4'd7;
	localparam logic [3:0] S_BLINK = 4'd8;
	localparam logic [3:0] S_BACC  = 4'd9;
	localparam logic [3:0] S_BRD1  = 4'd10;
	localparam logic [3:0] S_BRD2  = 4'd11;
	localparam logic [3:0] S_BWR   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and datapath commands
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				ctl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					if (stat.bad) begin
						ctl.err = 1'b1;
					end else begin
						case (command)
							wmpm_pkg::CMD_LETTER: begin
								ctl.ins_rd = 1'b1;
								state_d    = S_INS2;
							end
							wmpm_pkg::CMD_END: begin
								ctl.end_rd = 1'b1;
								state_d    = S_END2;
							end
							wmpm_pkg::CMD_BUILD: begin
								ctl.b_init = 1'b1;
								state_d    = S_BPOP;
							end
							wmpm_pkg::CMD_MATCH: begin
								ctl.mat_rd = 1'b1;
								state_d    = S_MAT2;
							end
							wmpm_pkg::CMD_RESTART: begin
								ctl.restart = 1'b1;
							end
							wmpm_pkg::CMD_CLEAR: begin
								ctl.clr_all = 1'b1;
								state_d     = S_CLR;
							end
							default: begin
								ctl.err = 1'b1;
							end
						endcase
					end
				end
			end
			S_INS2: begin
				ctl.ins_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_END2: begin
				ctl.end_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_MAT2: begin
				ctl.mat_acc = 1'b1;
				state_d     = S_MAT3;
			end
			S_MAT3: begin
				ctl.mat_fin = 1'b1;
				state_d     = S_IDLE;
			end
			S_BPOP: begin
				ctl.b_pop = 1'b1;
				state_d   = S_BPOPW;
			end
			S_BPOPW: begin
				ctl.b_popw = 1'b1;
				state_d    = S_BLINK;
			end
			S_BLINK: begin
				ctl.b_link = 1'b1;
				state_d    = S_BACC;
			end
			S_BACC: begin
				ctl.b_acc = 1'b1;
				state_d   = S_BRD1;
			end
			S_BRD1: begin
				ctl.b_rd1 = 1'b1;
				state_d   = S_BRD2;
			end
			S_BRD2: begin
				ctl.b_rd2 = 1'b1;
				state_d   = S_BWR;
			end
			S_BWR: begin
				ctl.b_wr = 1'b1;
				if (!stat.c_last) begin
					state_d = S_BRD1;
				end else if (stat.q_more) begin
					state_d = S_BPOP;
				end else begin
					ctl.b_fin = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register, sweep runs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== src/wmpm_dp.sv =====
`timescale 1ns / 1ps
// datapath of the matcher: trie memories, build queue, cursors, scores and result register
// depends on wmpm_pkg and wmpm_ram
module wmpm_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  wmpm_pkg::req_t  req,
	input  wmpm_pkg::ctl_t  ctl,
	output wmpm_pkg::stat_t stat,
	output logic            done,
	output wmpm_pkg::res_t  res
);

	localparam int NW = wmpm_pkg::NODE_W;
	localparam int GW = wmpm_pkg::GOTO_AW;
	localparam int CW = wmpm_pkg::C_W;
	localparam int VW = wmpm_pkg::VAL_W;
	localparam int AW = wmpm_pkg::ACC_W;
	localparam int TW = wmpm_pkg::TOT_W;
	localparam int KW = wmpm_pkg::CNT_W;

	// control registers
	logic [NW-1:0] cursor_q;
	logic [NW-1:0] ms_q;
	logic [TW-1:0] total_q;
	logic [KW-1:0] count_q;
	logic          built_q;
	logic [GW-1:0] sweep_q;
	logic [KW-1:0] head_q;
	logic [KW-1:0] tail_q;
	logic [CW-1:0] c_q;
	logic          done_q;

	// payload registers
	logic [GW-1:0]   slot_q;
	logic [VW-1:0]   val_q;
	logic [NW-1:0]   v_q;
	logic [GW-1:0]   vbase_q;
	logic [GW-1:0]   lkbase_q;
	logic [NW-1:0]   child_q;
	wmpm_pkg::res_t  res_q;
	wmpm_pkg::res_t  res_d;

	// memory ports
	logic          g_we,  s_we,  v_we,  a_we,  q_we;
	logic [GW-1:0] g_waddr, g_raddr;
	logic [NW-1:0] s_waddr, v_waddr, v_raddr, a_waddr, a_raddr, q_waddr;
	logic [NW-1:0] g_wdata, g_rdata, s_wdata, s_rdata, q_wdata, q_rdata;
	logic [VW-1:0] v_wdata, v_rdata;
	logic [AW-1:0] a_wdata, a_rdata;

	logic          ch_bad;
	logic          req_bad;
	logic          sweep_last;
	logic          c_last;
	logic          q_more;
	logic          full;
	logic          small_sw;
	logic          child_nz;
	logic [GW-1:0] in_slot;
	logic [NW-1:0] err_node;
	logic [VW:0]   vsum;
	logic [VW-1:0] vsat;
	logic [AW:0]   asum;
	logic [AW-1:0] asat;
	logic [TW:0]   tsum;
	logic [TW-1:0] tsat;

	// request checks
	always_comb begin
		ch_bad = (req.char_code >= 5'(wmpm_pkg::ALPHABET));
		case (req.command)
			wmpm_pkg::CMD_LETTER:                  req_bad = built_q || ch_bad;
			wmpm_pkg::CMD_END, wmpm_pkg::CMD_BUILD: req_bad = built_q;
			wmpm_pkg::CMD_MATCH:                   req_bad = !built_q || ch_bad;
			wmpm_pkg::CMD_RESTART, wmpm_pkg::CMD_CLEAR: req_bad = 1'b0;
			default:                               req_bad = 1'b1;
		endcase
		case (req.command)
			wmpm_pkg::CMD_LETTER, wmpm_pkg::CMD_END: err_node = cursor_q;
			wmpm_pkg::CMD_MATCH:                     err_node = ms_q;
			default:                                 err_node = '0;
		endcase
	end

	assign sweep_last = (sweep_q == GW'(wmpm_pkg::GOTO_DEPTH - 1));
	assign c_last     = (c_q == CW'(wmpm_pkg::ALPHABET - 1));
	assign child_nz   = (child_q != '0);
	assign q_more     = (head_q != tail_q) || child_nz;
	assign stat       = {req_bad, sweep_last, c_last, q_more};

	assign full     = (count_q >= KW'(wmpm_pkg::MAX_NODES));
	assign small_sw = ctl.sweep && (sweep_q < GW'(wmpm_pkg::MAX_NODES));

	// saturating adders
	always_comb begin
		vsum = {1'b0, v_rdata} + {1'b0, val_q};
		vsat = vsum[VW] ? '1 : vsum[VW-1:0];
		asum = {1'b0, a_rdata} + (AW+1)'(v_rdata);
		asat = asum[AW] ? '1 : asum[AW-1:0];
		tsum = {1'b0, total_q} + (TW+1)'(a_rdata);
		tsat = tsum[TW] ? '1 : tsum[TW-1:0];
	end

	// goto table port selection
	always_comb begin
		in_slot = GW'(req.char_code);
		if (ctl.mat_rd) begin
			in_slot = wmpm_pkg::row_base(ms_q) + GW'(req.char_code);
		end else begin
			in_slot = wmpm_pkg::row_base(cursor_q) + GW'(req.char_code);
		end
		if (ctl.b_rd2) begin
			g_raddr = lkbase_q + GW'(c_q);
		end else if (ctl.ins_rd || ctl.mat_rd) begin
			g_raddr = in_slot;
		end else begin
			g_raddr = vbase_q + GW'(c_q);
		end
		g_we = ctl.sweep || (ctl.ins_wr && g_rdata == '0 && !full) ||
			(ctl.b_wr && !child_nz);
		if (ctl.sweep) begin
			g_waddr = sweep_q;
			g_wdata = '0;
		end else if (ctl.ins_wr) begin
			g_waddr = slot_q;
			g_wdata = count_q[NW-1:0];
		end else begin
			g_waddr = vbase_q + GW'(c_q);
			g_wdata = g_rdata;
		end
	end

	// per-node memories and build queue port selection
	always_comb begin
		s_we    = small_sw || (ctl.b_wr && child_nz);
		s_waddr = ctl.sweep ? sweep_q[NW-1:0] : child_q;
		s_wdata = (ctl.sweep || v_q == '0) ? '0 : g_rdata;
		v_we    = small_sw || ctl.end_wr;
		v_waddr = ctl.sweep ? sweep_q[NW-1:0] : cursor_q;
		v_wdata = ctl.sweep ? '0 : vsat;
		v_raddr = ctl.end_rd ? cursor_q : v_q;
		a_we    = small_sw || ctl.b_acc;
		a_waddr = ctl.sweep ? sweep_q[NW-1:0] : v_q;
		a_wdata = ctl.sweep ? '0 : asat;
		a_raddr = ctl.mat_acc ? g_rdata : s_rdata;
		q_we    = ctl.b_init || (ctl.b_wr && child_nz);
		q_waddr = ctl.b_init ? '0 : tail_q[NW-1:0];
		q_wdata = ctl.b_init ? '0 : child_q;
	end

	wmpm_ram #(.WIDTH(NW), .DEPTH(wmpm_pkg::GOTO_DEPTH)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	wmpm_ram #(.WIDTH(NW), .DEPTH(wmpm_pkg::MAX_NODES)) u_link (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(q_rdata), .rdata(s_rdata)
	);

	wmpm_ram #(.WIDTH(VW), .DEPTH(wmpm_pkg::MAX_NODES)) u_value (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	wmpm_ram #(.WIDTH(AW), .DEPTH(wmpm_pkg::MAX_NODES)) u_acc (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	wmpm_ram #(.WIDTH(NW), .DEPTH(wmpm_pkg::MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[NW-1:0]), .rdata(q_rdata)
	);

	// cursors, counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			ms_q     <= '0;
			total_q  <= '0;
			count_q  <= KW'(1);
			built_q  <= 1'b0;
			sweep_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			c_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ctl.err || ctl.restart || ctl.clr_all || ctl.ins_wr ||
				ctl.end_wr || ctl.mat_fin || ctl.b_fin;
			if (ctl.sweep) begin
				sweep_q <= sweep_q + GW'(1);
			end
			if (ctl.clr_all) begin
				cursor_q <= '0;
				ms_q     <= '0;
				total_q  <= '0;
				count_q  <= KW'(1);
				built_q  <= 1'b0;
				sweep_q  <= '0;
			end
			if (ctl.restart) begin
				ms_q    <= '0;
				total_q <= '0;
			end
			if (ctl.ins_wr) begin
				if (g_rdata != '0) begin
					cursor_q <= g_rdata;
				end else if (!full) begin
					cursor_q <= count_q[NW-1:0];
					count_q  <= count_q + KW'(1);
				end
			end
			if (ctl.end_wr) begin
				cursor_q <= '0;
			end
			if (ctl.mat_acc) begin
				ms_q <= g_rdata;
			end
			if (ctl.mat_fin) begin
				total_q <= tsat;
			end
			if (ctl.b_init) begin
				head_q <= '0;
				tail_q <= KW'(1);
			end
			if (ctl.b_pop) begin
				head_q <= head_q + KW'(1);
			end
			if (ctl.b_link) begin
				c_q <= '0;
			end
			if (ctl.b_wr) begin
				c_q <= c_q + CW'(1);
				if (child_nz) begin
					tail_q <= tail_q + KW'(1);
				end
			end
			if (ctl.b_fin) begin
				built_q <= 1'b1;
			end
		end
	end

	// payload captures along the build and request paths
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			slot_q <= in_slot;
			val_q  <= req.pattern_value;
		end
		if (ctl.b_popw) begin
			v_q     <= q_rdata;
			vbase_q <= wmpm_pkg::row_base(q_rdata);
		end
		if (ctl.b_link) begin
			lkbase_q <= wmpm_pkg::row_base(s_rdata);
		end
		if (ctl.b_rd2) begin
			child_q <= g_rdata;
		end
		res_q <= res_d;
	end

	// result forming
	always_comb begin
		res_d.status      = wmpm_pkg::ST_OK;
		res_d.node        = '0;
		res_d.step_score  = '0;
		res_d.total_score = total_q;
		if (ctl.err) begin
			res_d.status = wmpm_pkg::ST_BAD;
			res_d.node   = err_node;
		end else if (ctl.restart || ctl.clr_all) begin
			res_d.total_score = '0;
		end else if (ctl.ins_wr) begin
			if (g_rdata != '0) begin
				res_d.node = g_rdata;
			end else if (full) begin
				res_d.status = wmpm_pkg::ST_FULL;
				res_d.node   = cursor_q;
			end else begin
				res_d.node = count_q[NW-1:0];
			end
		end else if (ctl.end_wr) begin
			res_d.node = cursor_q;
		end else if (ctl.mat_fin) begin
			res_d.node        = ms_q;
			res_d.step_score  = a_rdata;
			res_d.total_score = tsat;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== src/weighted_multi_pattern_matcher.sv =====
`timescale 1ns / 1ps
// weighted multi-pattern matcher top level; depends on wmpm_pkg, wmpm_ctrl, wmpm_dp
// result strobe after accept: restart, clear and rejected requests answer directly from the accept,
// pattern letter and end pattern after a read then a write, match letter after goto read then score read
// build per trie node: pop, pop wait, link, accumulate, then per letter read, read, write on one goto port
// after reset and after clear a sweep zeroes the tables, busy until the last goto-table entry
// a new request is accepted only while not busy; results cannot be stalled, one strobe cycle each
`include "weighted_multi_pattern_matcher_macros.svh"
module weighted_multi_pattern_matcher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  wmpm_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output wmpm_pkg::res_t res
);

	wmpm_pkg::ctl_t  ctl;
	wmpm_pkg::stat_t stat;

	// sequencing
	wmpm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(req.command),
		.stat(stat), .ctl(ctl), .busy(busy)
	);

	// storage and arithmetic
	wmpm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .ctl(ctl),
		.stat(stat), .done(done), .res(res)
	);

	// every accepted request either answers at once or holds the block busy
	`WMPM_ASSERT_NXT(a_accept_progress, start && !busy, done || busy, "request lost")
	// rejected or full requests score nothing
	`WMPM_ASSERT_IMP(a_err_no_score, done && res.status != wmpm_pkg::ST_OK, res.step_score == '0, "score on error")
	// restart answers next cycle with an empty total
	`WMPM_ASSERT_NXT(a_restart_total, start && !busy && req.command == wmpm_pkg::CMD_RESTART, done && res.total_score == '0, "restart total")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for weighted_multi_pattern_matcher: trie loading, link build,
// scored matching, error statuses and clear; depends on wmpm_pkg and the matcher rtl
module testbench;
	import wmpm_pkg::*;

	localparam int STALL_LIMIT = 400000;

	// predictor of the automaton plus the queue of expected results
	class score_board;
		logic [NODE_W-1:0] nxt[GOTO_DEPTH];
		logic [NODE_W-1:0] fail_link[MAX_NODES];
		bit                marked[MAX_NODES];
		logic [VAL_W-1:0]  weight[MAX_NODES];
		logic [ACC_W-1:0]  gain[MAX_NODES];
		int unsigned       used_nodes;
		logic [NODE_W-1:0] cursor;
		logic [NODE_W-1:0] state;
		logic [TOT_W-1:0]  total;
		bit                built;
		res_t              awaited[$];
		int                mismatches;

		function void wipe();
			foreach (nxt[i]) nxt[i] = '0;
			foreach (fail_link[i]) begin
				fail_link[i] = '0;
				marked[i] = 0;
				weight[i] = '0;
				gain[i] = '0;
			end
			used_nodes = 1;
			cursor = '0;
			state = '0;
			total = '0;
			built = 0;
		endfunction

		// breadth-first pass: suffix links, completed goto rows, chain sums
		function void link_trie();
			int unsigned order[MAX_NODES];
			int unsigned head, tail, v, lk, child;
			longint unsigned sum;
			head = 0;
			tail = 1;
			order[0] = 0;
			fail_link[0] = '0;
			while (head < tail) begin
				v = order[head];
				head++;
				lk = fail_link[v];
				sum = gain[lk];
				if (marked[v]) begin
					sum += weight[v];
					if (sum > 64'hFF_FFFF_FFFF) sum = 64'hFF_FFFF_FFFF;
				end
				gain[v] = sum[ACC_W-1:0];
				for (int c = 0; c < ALPHABET; c++) begin
					child = nxt[v*ALPHABET+c];
					if (child != 0) begin
						fail_link[child] = (v != 0) ? nxt[lk*ALPHABET+c] : '0;
						if (tail < MAX_NODES) begin
							order[tail] = child;
							tail++;
						end
					end else begin
						nxt[v*ALPHABET+c] = nxt[lk*ALPHABET+c];
					end
				end
			end
		endfunction

		// work out the result of one accepted request
		function void note(req_t r);
			res_t e;
			int unsigned slot;
			longint unsigned sum;
			e = '0;
			case (r.command)
				CMD_LETTER: begin
					e.node = cursor;
					if (built || r.char_code >= ALPHABET) e.status = ST_BAD;
					else begin
						slot = cursor*ALPHABET + r.char_code;
						if (nxt[slot] == 0 && used_nodes >= MAX_NODES) e.status = ST_FULL;
						else begin
							if (nxt[slot] == 0) begin
								nxt[slot] = NODE_W'(used_nodes);
								used_nodes++;
							end
							cursor = nxt[slot];
							e.node = cursor;
						end
					end
				end
				CMD_END: begin
					e.node = cursor;
					if (built) e.status = ST_BAD;
					else begin
						marked[cursor] = 1;
						sum = longint'(weight[cursor]) + r.pattern_value;
						weight[cursor] = (sum > 64'hF_FFFF) ? '1 : sum[VAL_W-1:0];
						cursor = '0;
					end
				end
				CMD_BUILD: begin
					if (built) e.status = ST_BAD;
					else begin
						link_trie();
						built = 1;
					end
				end
				CMD_MATCH: begin
					e.node = state;
					if (!built || r.char_code >= ALPHABET) e.status = ST_BAD;
					else begin
						state = nxt[state*ALPHABET + r.char_code];
						e.node = state;
						e.step_score = gain[state];
						sum = longint'(total) + gain[state];
						total = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[TOT_W-1:0];
					end
				end
				CMD_RESTART: begin
					state = '0;
					total = '0;
				end
				CMD_CLEAR: wipe();
				default: e.status = ST_BAD;
			endcase
			e.total_score = total;
			awaited = {awaited, e};
		endfunction

		function void check(res_t got);
			res_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			e = awaited.pop_front();
			if (got.status !== e.status || got.node !== e.node ||
					got.step_score !== e.step_score || got.total_score !== e.total_score) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	res_t res;

	score_board sb;
	bit         idling = 1;
	int         stalled;
	int         n_items, n_matches, n_clears;

	weighted_multi_pattern_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	always #10 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) sb.check(res);
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		if ((start && !busy) || done) stalled <= 0;
		else stalled <= stalled + 1;
		if (stalled >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", sb.awaited.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// issue one request and wait for its acceptance
	task automatic put(logic [2:0] cmd, logic [4:0] ch, logic [VAL_W-1:0] val);
		req_t r;
		int gap;
		r.command = cmd;
		r.char_code = ch;
		r.pattern_value = val;
		gap = 0;
		if (idling) while ($urandom_range(99) < 7) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		sb.note(r);
		n_items++;
		if (cmd == CMD_MATCH) n_matches++;
		if (cmd == CMD_CLEAR) n_clears++;
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	// one pattern over the first span letters, then its weight
	task automatic pattern(int len, int span);
		for (int i = 0; i < len; i++)
			put(CMD_LETTER, 5'($urandom_range(span - 1)), VAL_W'($urandom));
		put(CMD_END, 5'($urandom), VAL_W'($urandom));
	endtask

	// clear, load patterns with some noise, build, then match
	task automatic session(int n_pat, int n_match, int span);
		put(CMD_CLEAR, 5'($urandom), VAL_W'($urandom));
		for (int p = 0; p < n_pat; p++) begin
			pattern($urandom_range(5), span);
			if ($urandom_range(9) == 0)
				put(3'($urandom_range(7)), 5'($urandom), VAL_W'($urandom));
		end
		drain();
		put(CMD_BUILD, 5'($urandom), VAL_W'($urandom));
		for (int m = 0; m < n_match; m++) begin
			case ($urandom_range(19))
				0: put(CMD_RESTART, 5'($urandom), VAL_W'($urandom));
				1: put(3'($urandom_range(7)), 5'($urandom), VAL_W'($urandom));
				2: put(CMD_MATCH, 5'($urandom_range(31)), VAL_W'($urandom));
				default: put(CMD_MATCH, 5'($urandom_range(span - 1)), VAL_W'($urandom));
			endcase
		end
	endtask

	initial begin
		sb = new();
		sb.wipe();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		stalled = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: phase errors, empty pattern, maximum weight, bad letters and commands
		put(CMD_MATCH, 5'd0, '0);
		put(CMD_END, 5'd0, 20'd3);
		put(CMD_LETTER, 5'd0, '0);
		put(CMD_LETTER, 5'd1, '0);
		put(CMD_END, 5'd31, '1);
		put(CMD_LETTER, 5'd1, '0);
		put(CMD_END, 5'd0, '1);
		put(CMD_LETTER, 5'd25, '0);
		put(CMD_LETTER, 5'd26, '0);
		put(CMD_LETTER, 5'd31, '0);
		put(CMD_END, 5'd0, 20'h55555);
		put(3'd6, 5'd0, '0);
		put(3'd7, 5'd31, '1);
		drain();
		put(CMD_BUILD, 5'd0, '0);
		put(CMD_BUILD, 5'd0, '0);
		put(CMD_LETTER, 5'd2, '0);
		put(CMD_END, 5'd0, 20'd9);
		put(CMD_MATCH, 5'd0, '0);
		put(CMD_MATCH, 5'd1, '0);
		put(CMD_MATCH, 5'd25, '0);
		put(CMD_MATCH, 5'd30, '0);
		put(CMD_RESTART, 5'd0, '0);
		put(CMD_MATCH, 5'd1, '0);

		// random sessions, one without any idling
		for (int s = 0; s < 5; s++) begin
			idling = (s != 2);
			session($urandom_range(6, 14), $urandom_range(30, 45), (s == 4) ? 26 : 3 + s);
		end
		idling = 1;

		// fill the node table with long chains, then overrun it
		put(CMD_CLEAR, '0, '0);
		for (int i = 0; i < 1030; i++) begin
			put(CMD_LETTER, 5'($urandom_range(25)), VAL_W'($urandom));
			if (i % 300 == 299) put(CMD_END, '0, VAL_W'($urandom));
		end
		put(CMD_END, '0, VAL_W'($urandom));
		drain();
		put(CMD_BUILD, '0, '0);
		for (int m = 0; m < 40; m++)
			put(CMD_MATCH, 5'($urandom_range(25)), VAL_W'($urandom));

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d requests: %0d match letters, %0d clears, a full node table",
			n_items, n_matches, n_clears);
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
